/* sv/kdt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and constants for the key double tap detector.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int REG_SLOTS   = 4;
    localparam int AGE_W       = 32;
    localparam int WINDOW_W    = 31;
    localparam int CODE_W      = 8;
    localparam int IDX_W       = 2;
    localparam int TAP_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_3 = 3'd5;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_KEY_DOWN = 2'd1,
        OP_KEY_UP   = 2'd2
    } op_t;

    // event broadcast to every cell
    typedef struct packed {
        logic              go;
        op_t               op;
        logic [CODE_W-1:0] code;
    } evt_t;

    // result selection handed from cell to cell, lowest slot wins
    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] index;
        logic [AGE_W-1:0] age;
    } chain_t;

endpackage : kdt_pkg
`default_nettype wire

/* sv/key_double_tap_detector.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_double_tap_detector
// Watches key slots for double taps; a row of slot cells, one result register.
// ----------------------------------------------------------------------------
// a hit pends in its cell, then loads into the output register once it is free
// throughput: one input per cycle; a key-down that hits n slots gives n results
//   at one per cycle while m_ready holds, from the single output register; a
//   further key-down waits until the pending results have moved into that register
// reset: ages zero, all slots armed, tap number one, config registers zero
module key_double_tap_detector
    import kdt_pkg::*;
#(
    parameter int NUM_KEYS = 4
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [1:0]            s_op,
    input  wire  [CODE_W-1:0]     s_key_code,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic [IDX_W-1:0]      m_key_index,
    output logic [AGE_W-1:0]      m_delta_ms,
    output logic [TAP_W-1:0]      m_tap_number,
    output logic                  m_last,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_COUNT = (NUM_KEYS < REG_SLOTS) ? NUM_KEYS : REG_SLOTS;

    logic [WINDOW_W-1:0] window_reg;
    logic [REG_SLOTS-1:0] enable_reg;
    logic [CODE_W-1:0]   code_reg [REG_SLOTS];

    logic [TAP_W-1:0]    tap_cnt_reg;
    logic                m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [AGE_W-1:0]    delta_reg;
    logic [TAP_W-1:0]    tap_reg;
    logic                last_reg;

    chain_t              chain [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] pend_vec;
    logic [SLOT_COUNT-1:0] grant_vec;
    evt_t                evt;
    logic                load;
    logic                last_one;
    logic                still_pend;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            enable_reg <= '0;
            for (int i = 0; i < REG_SLOTS; i++) begin
                code_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW: window_reg  <= cfg_data;
                REG_ENABLE: enable_reg  <= cfg_data[REG_SLOTS-1:0];
                REG_CODE_0: code_reg[0] <= cfg_data[CODE_W-1:0];
                REG_CODE_1: code_reg[1] <= cfg_data[CODE_W-1:0];
                REG_CODE_2: code_reg[2] <= cfg_data[CODE_W-1:0];
                REG_CODE_3: code_reg[3] <= cfg_data[CODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // move the lowest pending slot into the output register when it is free
    assign load       = (!m_valid_reg || m_ready) && chain[SLOT_COUNT].busy;
    assign last_one   = ((pend_vec & ~grant_vec) == '0);
    assign still_pend = chain[SLOT_COUNT].busy && !(load && last_one);

    // a key-down may only enter once the previous results have all left the cells
    assign s_ready = (s_op != OP_KEY_DOWN) || !still_pend;

    assign evt = '{go: s_valid && s_ready, op: op_t'(s_op), code: s_key_code};

    assign chain[0] = '{busy: 1'b0, index: '0, age: '0};

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        kdt_cell #(
            .SLOT (IDX_W'(g))
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .evt       (evt),
            .cfg_code  (code_reg[g]),
            .cfg_en    (enable_reg[g]),
            .window    (window_reg),
            .pop       (load),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .pend      (pend_vec[g]),
            .grant     (grant_vec[g])
        );
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            tap_cnt_reg <= TAP_W'(1);
        end else begin
            m_valid_reg <= m_valid_next;
            if (load) begin
                tap_cnt_reg <= tap_cnt_reg + 1'b1;
            end
        end
        if (load) begin
            idx_reg   <= chain[SLOT_COUNT].index;
            delta_reg <= chain[SLOT_COUNT].age;
            tap_reg   <= tap_cnt_reg;
            last_reg  <= last_one;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_key_index  = idx_reg;
    assign m_delta_ms   = delta_reg;
    assign m_tap_number = tap_reg;
    assign m_last       = last_reg;

endmodule : key_double_tap_detector
`default_nettype wire

/* sv/kdt_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kdt_cell
// One watched key slot: age counter, armed flag and a pending result.
// ----------------------------------------------------------------------------
module kdt_cell
    import kdt_pkg::*;
#(
    parameter logic [IDX_W-1:0] SLOT = '0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire  evt_t          evt,
    input  wire  [CODE_W-1:0]   cfg_code,
    input  wire                 cfg_en,
    input  wire  [WINDOW_W-1:0] window,
    input  wire                 pop,
    input  wire  chain_t        chain_in,
    output chain_t              chain_out,
    output logic                pend,
    output logic                grant
);

    logic [AGE_W-1:0] age_reg, age_next;
    logic             armed_reg, armed_next;
    logic             pend_reg, pend_next;
    logic [AGE_W-1:0] pend_age_reg, pend_age_next;
    logic             match;

    assign match = (evt.code == cfg_code);
    assign grant = pend_reg && !chain_in.busy;
    assign pend  = pend_reg;

    always_comb begin
        chain_out.busy = chain_in.busy | pend_reg;
        if (grant) begin
            chain_out.index = SLOT;
            chain_out.age   = pend_age_reg;
        end else begin
            chain_out.index = chain_in.index;
            chain_out.age   = chain_in.age;
        end
    end

    always_comb begin
        age_next      = age_reg;
        armed_next    = armed_reg;
        pend_next     = pend_reg;
        pend_age_next = pend_age_reg;
        if (pop && grant) begin
            pend_next = 1'b0;
        end
        if (evt.go) begin
            case (evt.op)
                OP_TICK: begin
                    if (age_reg != '1) begin
                        age_next = age_reg + 1'b1;
                    end
                end
                OP_KEY_DOWN: begin
                    if (cfg_en && armed_reg && match) begin
                        if (age_reg <= {1'b0, window}) begin
                            pend_next     = 1'b1;
                            pend_age_next = age_reg;
                        end
                        age_next   = '0;
                        armed_next = 1'b0;
                    end
                end
                OP_KEY_UP: begin
                    if (match) begin
                        armed_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg   <= '0;
            armed_reg <= 1'b1;
            pend_reg  <= 1'b0;
        end else begin
            age_reg   <= age_next;
            armed_reg <= armed_next;
            pend_reg  <= pend_next;
        end
        pend_age_reg <= pend_age_next;
    end

endmodule : kdt_cell
`default_nettype wire

/* test/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for key_double_tap_detector: a queue-fed event driver,
// a result monitor and an event-level model of the slot ages, armed flags and
// tap number, run over several register settings with random handshake gaps.
// ----------------------------------------------------------------------------
module tb_top
    import kdt_pkg::*;
;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [1:0]        op;
        logic [CODE_W-1:0] code;
    } key_event_t;

    typedef struct packed {
        logic [IDX_W-1:0] key_index;
        logic [AGE_W-1:0] delta_ms;
        logic [TAP_W-1:0] tap_number;
        logic             last;
    } tap_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op = '0;
    logic [CODE_W-1:0]     s_key_code = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [IDX_W-1:0]      m_key_index;
    logic [AGE_W-1:0]      m_delta_ms;
    logic [TAP_W-1:0]      m_tap_number;
    logic                  m_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model of the block
    logic [AGE_W-1:0]    slot_age [REG_SLOTS];
    logic                slot_armed [REG_SLOTS];
    logic [CODE_W-1:0]   slot_code [REG_SLOTS];
    logic [TAP_W-1:0]    next_tap;
    logic [WINDOW_W-1:0] window_ms;
    logic [3:0]          enable_mask;

    key_event_t  pending_events [$];
    tap_result_t expected_taps [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;
    int n_events = 0;
    int n_taps = 0;
    int n_writes = 0;
    int n_errors = 0;

    key_double_tap_detector uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key_code   (s_key_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_key_index  (m_key_index),
        .m_delta_ms   (m_delta_ms),
        .m_tap_number (m_tap_number),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // advance the model by one event and queue the double taps it reports
    task automatic predict_taps(input logic [1:0] op, input logic [CODE_W-1:0] code);
        tap_result_t hit [REG_SLOTS];
        int n;
        n = 0;
        case (op)
            OP_TICK: begin
                for (int i = 0; i < REG_SLOTS; i++)
                    if (slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
            end
            OP_KEY_DOWN: begin
                for (int i = 0; i < REG_SLOTS; i++) begin
                    if (enable_mask[i] && slot_armed[i] && slot_code[i] == code) begin
                        if (slot_age[i] <= {1'b0, window_ms}) begin
                            hit[n].key_index  = IDX_W'(i);
                            hit[n].delta_ms   = slot_age[i];
                            hit[n].tap_number = next_tap;
                            hit[n].last       = 1'b0;
                            next_tap = next_tap + 1'b1;
                            n++;
                        end
                        slot_age[i]   = '0;
                        slot_armed[i] = 1'b0;
                    end
                end
                for (int k = 0; k < n; k++) begin
                    hit[k].last = (k == n - 1);
                    expected_taps.insert(expected_taps.size(), hit[k]);
                end
            end
            OP_KEY_UP: begin
                for (int i = 0; i < REG_SLOTS; i++)
                    if (slot_code[i] == code) slot_armed[i] = 1'b1;
            end
            default: ;
        endcase
    endtask

    // event driver
    always @(posedge aclk) begin : event_driver
        key_event_t ev;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_taps(s_op, s_key_code);
                n_events++;
            end
            if (!s_valid || s_ready) begin
                if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    ev = pending_events.pop_front();
                    s_valid    <= 1'b1;
                    s_op       <= ev.op;
                    s_key_code <= ev.code;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor
    always @(posedge aclk) begin : tap_monitor
        tap_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_taps.size() == 0) begin
                $error("result with nothing expected: key_index %0d delta_ms %0d tap_number %0d",
                       m_key_index, m_delta_ms, m_tap_number);
                n_errors++;
            end else begin
                want = expected_taps.pop_front();
                n_taps++;
                if (m_key_index !== want.key_index) begin
                    $error("key_index mismatch: expected %0d, got %0d",
                           want.key_index, m_key_index);
                    n_errors++;
                end
                if (m_delta_ms !== want.delta_ms) begin
                    $error("delta_ms mismatch: expected %0d, got %0d", want.delta_ms, m_delta_ms);
                    n_errors++;
                end
                if (m_tap_number !== want.tap_number) begin
                    $error("tap_number mismatch: expected %0d, got %0d",
                           want.tap_number, m_tap_number);
                    n_errors++;
                end
                if (m_last !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d", want.last, m_last);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: counts cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_WINDOW: window_ms = data[WINDOW_W-1:0];
            REG_ENABLE: enable_mask = data[3:0];
            REG_CODE_0, REG_CODE_1, REG_CODE_2, REG_CODE_3:
                slot_code[idx - REG_CODE_0] = data[CODE_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        n_writes++;
    endtask

    task automatic queue_event(input logic [1:0] op, input logic [CODE_W-1:0] code);
        key_event_t ev;
        ev.op   = op;
        ev.code = code;
        pending_events.insert(pending_events.size(), ev);
    endtask

    // wait for the driver and monitor to run dry, then let the block settle
    task automatic drain(input int settle);
        do @(negedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_taps.size() != 0);
        repeat (settle) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0: begin send_idle_pct = 6;  recv_idle_pct = 61; end
            1: begin send_idle_pct = 61; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endtask

    // slot codes drawn from a small pool so that slots often share a code
    task automatic set_codes();
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i < REG_SLOTS; i++) begin
            data = CFG_DATA_W'($urandom);
            case ($urandom_range(5))
                0: data[CODE_W-1:0] = 8'h00;
                1: data[CODE_W-1:0] = 8'hFF;
                2: data[CODE_W-1:0] = 8'h55;
                3: data[CODE_W-1:0] = 8'hAA;
                4: data[CODE_W-1:0] = 8'h41;
                default: data[CODE_W-1:0] = CODE_W'($urandom_range(255));
            endcase
            write_reg(REG_CODE_0 + CFG_IDX_W'(i), data);
        end
    endtask

    // mostly press-release-press-release sequences on watched codes, plus noise
    task automatic random_taps(input int quota);
        int count;
        int gap_max;
        int gap;
        int pick;
        logic [CODE_W-1:0] code;
        count = 0;
        gap_max = (window_ms < 8) ? int'(window_ms) + 2 : 6;
        @(negedge aclk);
        while (count < quota) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                code = slot_code[IDX_W'($urandom_range(REG_SLOTS - 1))];
                gap  = $urandom_range(gap_max);
                queue_event(OP_KEY_DOWN, code);
                queue_event(OP_KEY_UP, code);
                repeat (gap) queue_event(OP_TICK, CODE_W'($urandom_range(255)));
                queue_event(OP_KEY_DOWN, code);
                queue_event(OP_KEY_UP, code);
                count += 4 + gap;
            end else if (pick < 85) begin
                gap = $urandom_range(1, 3);
                repeat (gap) queue_event(OP_TICK, CODE_W'($urandom_range(255)));
                count += gap;
            end else begin
                code = CODE_W'($urandom_range(255));
                pick = $urandom_range(3);
                queue_event(2'(pick), code);
                if (2'(pick) != OP_UNUSED) count++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < REG_SLOTS; i++) begin
            slot_age[i]   = '0;
            slot_armed[i] = 1'b1;
            slot_code[i]  = '0;
        end
        next_tap    = 1;
        window_ms   = '0;
        enable_mask = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: shared code on two slots, extreme codes, window edge
        set_idle(0);
        write_reg(REG_WINDOW, 31'd5);
        write_reg(REG_ENABLE, 31'hF);
        write_reg(REG_CODE_0, 31'h00);
        write_reg(REG_CODE_1, 31'hFF);
        write_reg(REG_CODE_2, 31'h41);
        write_reg(REG_CODE_3, 31'h41);
        @(negedge aclk);
        queue_event(OP_KEY_DOWN, 8'h41);   // both shared slots tap at age zero
        queue_event(OP_KEY_DOWN, 8'h41);   // disarmed, nothing
        queue_event(OP_KEY_UP, 8'h41);
        repeat (3) queue_event(OP_TICK, 8'hFF);
        queue_event(OP_KEY_DOWN, 8'h41);
        queue_event(OP_UNUSED, 8'h41);     // ignored
        queue_event(OP_KEY_UP, 8'h41);
        repeat (6) queue_event(OP_TICK, 8'h00);
        queue_event(OP_KEY_DOWN, 8'h41);   // age past window: no result, disarms
        queue_event(OP_KEY_DOWN, 8'h00);
        queue_event(OP_KEY_UP, 8'h00);
        queue_event(OP_KEY_DOWN, 8'h00);
        queue_event(OP_KEY_DOWN, 8'hFF);
        queue_event(OP_KEY_UP, 8'hFF);
        queue_event(OP_TICK, 8'h00);
        queue_event(OP_KEY_DOWN, 8'hFF);
        queue_event(OP_KEY_UP, 8'h41);
        queue_event(OP_KEY_UP, 8'hFF);
        drain(4);

        // zero window, partly disabled slots, writes to unused indexes
        set_idle(0);
        write_reg(REG_WINDOW, 31'd0);
        write_reg(REG_ENABLE, 31'h5);
        set_codes();
        write_reg(REG_SPARE_6, '1);
        write_reg(REG_SPARE_7, '1);
        random_taps(30);
        drain(4);

        // widest window
        set_idle(1);
        write_reg(REG_WINDOW, 31'h7FFF_FFFF);
        write_reg(REG_ENABLE, 31'hF);
        set_codes();
        random_taps(30);
        drain(4);

        // all slots disabled: key-ups still re-arm
        set_idle(1);
        write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(12)));
        write_reg(REG_ENABLE, 31'h0);
        set_codes();
        random_taps(20);
        drain(4);

        set_idle(2);
        write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(1, 10)));
        write_reg(REG_ENABLE, CFG_DATA_W'($urandom));
        set_codes();
        random_taps(35);
        drain(4);

        set_idle(2);
        write_reg(REG_WINDOW, CFG_DATA_W'($urandom));
        write_reg(REG_ENABLE, 31'hF);
        set_codes();
        random_taps(35);
        drain(8);

        $display("ran %0d key events and %0d register writes over six settings",
                 n_events, n_writes);
        $display("checked %0d double tap results, %0d mismatches", n_taps, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule : tb_top
`default_nettype wire
